>>> design/vcid_pkg.sv
// Shared types and constants for the vector CPU instruction decoder.
// No dependencies; imported by the decoder, its checker and the testbench.
`timescale 1ns / 1ps

package vcid_pkg;

    // Execution modes
    localparam logic [1:0] MODE_NOP = 2'd0;
    localparam logic [1:0] MODE_SS  = 2'd1;
    localparam logic [1:0] MODE_VV  = 2'd2;
    localparam logic [1:0] MODE_VS  = 2'd3;

    // Instruction types
    localparam logic [1:0] TYPE_ARITH = 2'd0;
    localparam logic [1:0] TYPE_LOGIC = 2'd1;
    localparam logic [1:0] TYPE_MOVE  = 2'd2;
    localparam logic [1:0] TYPE_HALT  = 2'd3;

    // Opcodes with a fixed meaning
    localparam logic [3:0] OPC_SUB        = 4'd1;
    localparam logic [3:0] OPC_ASSIGN     = 4'd0;
    localparam logic [3:0] OPC_STORE      = 4'd1;
    localparam logic [3:0] OPC_LOAD       = 4'd2;
    localparam logic [3:0] OPC_LOGIC_LAST = 4'h6;
    localparam logic [3:0] OPC_DUMP       = 4'd15;

    // ALU operation codes
    localparam logic [3:0] ALU_ADD  = 4'd0;
    localparam logic [3:0] ALU_SUB  = 4'd1;
    localparam logic [3:0] ALU_OR   = 4'd2;
    localparam logic [3:0] ALU_AND  = 4'd3;
    localparam logic [3:0] ALU_XOR  = 4'd4;
    localparam logic [3:0] ALU_SHL  = 4'd5;
    localparam logic [3:0] ALU_SHR  = 4'd6;
    localparam logic [3:0] ALU_ADDR = 4'd9;
    localparam logic [3:0] ALU_PASS = 4'd10;
    localparam logic [3:0] ALU_ROL  = 4'd11;
    localparam logic [3:0] ALU_ROR  = 4'd12;

    // Register read enables
    localparam logic [1:0] RREAD_NONE   = 2'd0;
    localparam logic [1:0] RREAD_SCALAR = 2'd1;
    localparam logic [1:0] RREAD_VECTOR = 2'd2;
    localparam logic [1:0] RREAD_BOTH   = 2'd3;

    // One decoded control word
    typedef struct packed {
        logic [3:0] scalar_alu_select;
        logic       scalar_reg_write;
        logic       use_immediate;
        logic       vector_reg_write;
        logic       input_select;
        logic       mem_read;
        logic       mem_write;
        logic [3:0] vector_alu_select;
        logic       memory_dump;
        logic [1:0] mode_echo;
        logic [1:0] register_read;
        logic       run_enable;
    } ctrl_t;

    // Arithmetic ALU code: only sub is special, everything else adds
    function automatic logic [3:0] arith_sel(input logic [3:0] op);
        arith_sel = (op == OPC_SUB) ? ALU_SUB : ALU_ADD;
    endfunction

    // Logic ALU code; opcodes past the list give 0
    function automatic logic [3:0] logic_sel(input logic [3:0] op);
        unique case (op)
            4'd0:    logic_sel = ALU_AND;
            4'd1:    logic_sel = ALU_OR;
            4'd2:    logic_sel = ALU_XOR;
            4'd3:    logic_sel = ALU_SHR;
            4'd4:    logic_sel = ALU_SHL;
            4'd5:    logic_sel = ALU_ROR;
            4'd6:    logic_sel = ALU_ROL;
            default: logic_sel = ALU_ADD;
        endcase
    endfunction

endpackage

>>> design/vector_cpu_instruction_decoder.sv
// Instruction decoder: input register, decode logic, control output register.
// Depends on vcid_pkg.
`timescale 1ns / 1ps

// An accepted request waits in the input register, then is decoded into the output register.
// Throughput: one request per cycle while out_stall is low; the decode is a single shallow lookup
//   between the input register and the output register.
// in_stall rises only while the input register holds a request and the output
//   register is full and stalled; out_valid comes straight from a register.
// Reset (rst_n low, asynchronous): both stages empty, halted flag cleared.
module vector_cpu_instruction_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    // request channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [1:0] instr_type,
    input  logic       immediate_flag,
    input  logic [3:0] opcode,
    // control word channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] scalar_alu_select,
    output logic       scalar_reg_write,
    output logic       use_immediate,
    output logic       vector_reg_write,
    output logic       input_select,
    output logic       mem_read,
    output logic       mem_write,
    output logic [3:0] vector_alu_select,
    output logic       memory_dump,
    output logic [1:0] mode_echo,
    output logic [1:0] register_read,
    output logic       run_enable
);
    import vcid_pkg::*;

    // Input stage
    logic       s1_valid_reg, s1_valid_next;
    logic [1:0] s1_mode_reg;
    logic [1:0] s1_type_reg;
    logic       s1_imm_reg;
    logic [3:0] s1_op_reg;

    // Output stage
    logic       out_valid_reg, out_valid_next;
    ctrl_t      ctrl_reg;
    ctrl_t      ctrl_next;

    // Sticky halt flag
    logic       halted_reg, halted_next;

    logic       in_take;     // request accepted into input stage
    logic       out_free;    // output register can load this cycle
    logic       out_load;    // input stage moves to output register
    logic       is_halt;     // input stage holds a halt
    logic       decoded;     // input stage holds a listed instruction

    // A stalled result holds the output register; the input stage then holds too.
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (out_free)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign is_halt     = (s1_mode_reg == MODE_NOP) && (s1_type_reg == TYPE_HALT);
    assign halted_next = halted_reg || (out_load && is_halt);

    // Decode of the held request
    always_comb
    begin
        ctrl_next = '0;
        decoded   = 1'b0;
        unique case (s1_mode_reg)
            MODE_NOP:
            begin
                if (s1_type_reg != TYPE_HALT && s1_op_reg == OPC_DUMP)
                    ctrl_next.memory_dump = 1'b1;
            end
            MODE_SS:
            begin
                if (s1_type_reg == TYPE_ARITH || s1_type_reg == TYPE_LOGIC)
                begin
                    decoded                     = 1'b1;
                    ctrl_next.register_read     = RREAD_SCALAR;
                    ctrl_next.scalar_alu_select = (s1_type_reg == TYPE_ARITH)
                                                ? arith_sel(s1_op_reg)
                                                : logic_sel(s1_op_reg);
                    ctrl_next.scalar_reg_write  = 1'b1;
                    ctrl_next.use_immediate     = s1_imm_reg;
                end
                else if (s1_type_reg == TYPE_MOVE && s1_op_reg <= OPC_LOAD)
                begin
                    decoded                 = 1'b1;
                    ctrl_next.register_read = RREAD_SCALAR;
                    ctrl_next.use_immediate = s1_imm_reg;
                    if (s1_op_reg == OPC_STORE)
                    begin
                        ctrl_next.scalar_alu_select = ALU_ADDR;
                        ctrl_next.mem_write         = 1'b1;
                    end
                    else
                    begin
                        ctrl_next.scalar_alu_select = ALU_PASS;
                        ctrl_next.scalar_reg_write  = 1'b1;
                        ctrl_next.mem_read          = (s1_op_reg == OPC_LOAD);
                    end
                end
            end
            MODE_VV:
            begin
                if (s1_type_reg == TYPE_ARITH || s1_type_reg == TYPE_LOGIC
                    || (s1_type_reg == TYPE_MOVE && s1_op_reg == OPC_ASSIGN))
                begin
                    decoded                    = 1'b1;
                    ctrl_next.register_read    = RREAD_VECTOR;
                    ctrl_next.vector_reg_write = 1'b1;
                    ctrl_next.input_select     = 1'b1;
                    if (s1_type_reg == TYPE_ARITH)
                        ctrl_next.vector_alu_select = arith_sel(s1_op_reg);
                    else if (s1_type_reg == TYPE_LOGIC)
                        ctrl_next.vector_alu_select = logic_sel(s1_op_reg);
                    else
                        ctrl_next.vector_alu_select = ALU_PASS;
                end
            end
            MODE_VS:
            begin
                if (s1_type_reg == TYPE_ARITH || s1_type_reg == TYPE_LOGIC)
                begin
                    decoded                     = 1'b1;
                    ctrl_next.register_read     = RREAD_BOTH;
                    ctrl_next.use_immediate     = 1'b1;
                    ctrl_next.vector_reg_write  = 1'b1;
                    ctrl_next.input_select      = 1'b1;
                    ctrl_next.vector_alu_select = (s1_type_reg == TYPE_ARITH)
                                                ? arith_sel(s1_op_reg)
                                                : logic_sel(s1_op_reg);
                end
                else if (s1_type_reg == TYPE_MOVE && s1_op_reg == OPC_STORE)
                begin
                    decoded                     = 1'b1;
                    ctrl_next.register_read     = RREAD_BOTH;
                    ctrl_next.scalar_alu_select = ALU_PASS;
                    ctrl_next.use_immediate     = s1_imm_reg;
                    ctrl_next.input_select      = 1'b1;
                    ctrl_next.mem_write         = 1'b1;
                    ctrl_next.vector_alu_select = ALU_ADDR;
                end
                else if (s1_type_reg == TYPE_MOVE && s1_op_reg == OPC_LOAD)
                begin
                    decoded                     = 1'b1;
                    ctrl_next.register_read     = RREAD_SCALAR;
                    ctrl_next.scalar_alu_select = ALU_PASS;
                    ctrl_next.use_immediate     = s1_imm_reg;
                    ctrl_next.vector_reg_write  = 1'b1;
                    ctrl_next.input_select      = 1'b1;
                    ctrl_next.mem_read          = 1'b1;
                end
            end
            default:
            begin
                decoded = 1'b0;
            end
        endcase

        if (decoded)
            ctrl_next.mode_echo = s1_mode_reg;
        // the halting instruction itself already sees run disabled
        ctrl_next.run_enable = !(halted_reg || is_halt);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            halted_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            halted_reg    <= halted_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg <= mode;
            s1_type_reg <= instr_type;
            s1_imm_reg  <= immediate_flag;
            s1_op_reg   <= opcode;
        end
        if (out_load)
            ctrl_reg <= ctrl_next;
    end

    assign out_valid         = out_valid_reg;
    assign scalar_alu_select = ctrl_reg.scalar_alu_select;
    assign scalar_reg_write  = ctrl_reg.scalar_reg_write;
    assign use_immediate     = ctrl_reg.use_immediate;
    assign vector_reg_write  = ctrl_reg.vector_reg_write;
    assign input_select      = ctrl_reg.input_select;
    assign mem_read          = ctrl_reg.mem_read;
    assign mem_write         = ctrl_reg.mem_write;
    assign vector_alu_select = ctrl_reg.vector_alu_select;
    assign memory_dump       = ctrl_reg.memory_dump;
    assign mode_echo         = ctrl_reg.mode_echo;
    assign register_read     = ctrl_reg.register_read;
    assign run_enable        = ctrl_reg.run_enable;

    // A halt moving to the output sets the sticky flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && is_halt) |=> halted_reg)
        else $error("halt did not set halted flag");

    // Once halted, every shown control word has run disabled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && halted_reg) |-> !ctrl_reg.run_enable)
        else $error("run enabled after halt");

    // A dump request carries no other decoded controls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ctrl_reg.memory_dump)
        |-> (ctrl_reg.mode_echo == MODE_NOP && ctrl_reg.register_read == RREAD_NONE))
        else $error("dump mixed with decoded instruction");

    // A decoded instruction always reads some register file.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ctrl_reg.mode_echo != MODE_NOP)
        |-> (ctrl_reg.register_read != RREAD_NONE))
        else $error("decoded instruction without register read");

endmodule

>>> test/vcid_decode_checker.sv
// Checker for the instruction decoder: watches both channels, predicts each control word
// and compares it field by field. Depends on vcid_pkg.
`timescale 1ns / 1ps

module vcid_decode_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] mode,
    input  logic [1:0] instr_type,
    input  logic       immediate_flag,
    input  logic [3:0] opcode,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [3:0] scalar_alu_select,
    input  logic       scalar_reg_write,
    input  logic       use_immediate,
    input  logic       vector_reg_write,
    input  logic       input_select,
    input  logic       mem_read,
    input  logic       mem_write,
    input  logic [3:0] vector_alu_select,
    input  logic       memory_dump,
    input  logic [1:0] mode_echo,
    input  logic [1:0] register_read,
    input  logic       run_enable,
    output int         fail_count,
    output int         outstanding,
    output int         word_count,
    output int         dump_count,
    output int         halted_words
);
    import vcid_pkg::*;

    ctrl_t expected_ctrl[$];
    ctrl_t want;
    logic  halt_seen;
    int    n_fail;
    int    n_words;
    int    n_dumps;
    int    n_halted;

    assign fail_count   = n_fail;
    assign word_count   = n_words;
    assign dump_count   = n_dumps;
    assign halted_words = n_halted;

    // Shift/rotate/bitwise group; anything past the list falls back to add
    function automatic logic [3:0] logic_code(input logic [3:0] op);
        case (op)
            4'd0:    logic_code = ALU_AND;
            4'd1:    logic_code = ALU_OR;
            4'd2:    logic_code = ALU_XOR;
            4'd3:    logic_code = ALU_SHR;
            4'd4:    logic_code = ALU_SHL;
            4'd5:    logic_code = ALU_ROR;
            4'd6:    logic_code = ALU_ROL;
            default: logic_code = ALU_ADD;
        endcase
    endfunction

    function automatic ctrl_t decode_ctrl(input logic [1:0] m, input logic [1:0] t,
                                          input logic im, input logic [3:0] op,
                                          input logic stopped);
        ctrl_t c;
        logic  hit;
        logic [3:0] alu;
        c   = '0;
        hit = 1'b0;
        alu = (t == TYPE_ARITH) ? ((op == OPC_SUB) ? ALU_SUB : ALU_ADD) : logic_code(op);
        case (m)
            MODE_NOP:
            begin
                if (t != TYPE_HALT && op == OPC_DUMP)
                    c.memory_dump = 1'b1;
            end
            MODE_SS:
            begin
                if (t == TYPE_ARITH || t == TYPE_LOGIC)
                begin
                    hit = 1'b1;
                    c.register_read     = RREAD_SCALAR;
                    c.scalar_alu_select = alu;
                    c.scalar_reg_write  = 1'b1;
                    c.use_immediate     = im;
                end
                else if (t == TYPE_MOVE && op <= OPC_LOAD)
                begin
                    hit = 1'b1;
                    c.register_read = RREAD_SCALAR;
                    c.use_immediate = im;
                    if (op == OPC_STORE)
                    begin
                        c.scalar_alu_select = ALU_ADDR;
                        c.mem_write         = 1'b1;
                    end
                    else
                    begin
                        c.scalar_alu_select = ALU_PASS;
                        c.scalar_reg_write  = 1'b1;
                        c.mem_read          = (op == OPC_LOAD);
                    end
                end
            end
            MODE_VV:
            begin
                if (t == TYPE_ARITH || t == TYPE_LOGIC || (t == TYPE_MOVE && op == OPC_ASSIGN))
                begin
                    hit = 1'b1;
                    c.register_read     = RREAD_VECTOR;
                    c.vector_reg_write  = 1'b1;
                    c.input_select      = 1'b1;
                    c.vector_alu_select = (t == TYPE_MOVE) ? ALU_PASS : alu;
                end
            end
            default:
            begin
                if (t == TYPE_ARITH || t == TYPE_LOGIC)
                begin
                    hit = 1'b1;
                    c.register_read     = RREAD_BOTH;
                    c.use_immediate     = 1'b1;
                    c.vector_reg_write  = 1'b1;
                    c.input_select      = 1'b1;
                    c.vector_alu_select = alu;
                end
                else if (t == TYPE_MOVE && op == OPC_STORE)
                begin
                    hit = 1'b1;
                    c.register_read     = RREAD_BOTH;
                    c.scalar_alu_select = ALU_PASS;
                    c.use_immediate     = im;
                    c.input_select      = 1'b1;
                    c.mem_write         = 1'b1;
                    c.vector_alu_select = ALU_ADDR;
                end
                else if (t == TYPE_MOVE && op == OPC_LOAD)
                begin
                    hit = 1'b1;
                    c.register_read     = RREAD_SCALAR;
                    c.scalar_alu_select = ALU_PASS;
                    c.use_immediate     = im;
                    c.vector_reg_write  = 1'b1;
                    c.input_select      = 1'b1;
                    c.mem_read          = 1'b1;
                end
            end
        endcase
        if (hit)
            c.mode_echo = m;
        c.run_enable = !stopped;
        return c;
    endfunction

    task automatic check_field(input string name, input logic [3:0] exp_v,
                               input logic [3:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            n_fail++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_ctrl.delete();
            halt_seen = 1'b0;
            n_fail    = 0;
            n_words   = 0;
            n_dumps   = 0;
            n_halted  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_ctrl.size() == 0)
                begin
                    $error("control word with no request waiting");
                    n_fail++;
                end
                else
                begin
                    want = expected_ctrl.pop_front();
                    n_words++;
                    if (want.memory_dump)
                        n_dumps++;
                    if (!want.run_enable)
                        n_halted++;
                    check_field("scalar_alu_select", want.scalar_alu_select,
                                scalar_alu_select);
                    check_field("scalar_reg_write", 4'(want.scalar_reg_write),
                                4'(scalar_reg_write));
                    check_field("use_immediate", 4'(want.use_immediate),
                                4'(use_immediate));
                    check_field("vector_reg_write", 4'(want.vector_reg_write),
                                4'(vector_reg_write));
                    check_field("input_select", 4'(want.input_select),
                                4'(input_select));
                    check_field("mem_read", 4'(want.mem_read), 4'(mem_read));
                    check_field("mem_write", 4'(want.mem_write), 4'(mem_write));
                    check_field("vector_alu_select", want.vector_alu_select,
                                vector_alu_select);
                    check_field("memory_dump", 4'(want.memory_dump), 4'(memory_dump));
                    check_field("mode_echo", 4'(want.mode_echo), 4'(mode_echo));
                    check_field("register_read", 4'(want.register_read),
                                4'(register_read));
                    check_field("run_enable", 4'(want.run_enable), 4'(run_enable));
                end
            end
            if (in_valid && !in_stall)
            begin
                if (mode == MODE_NOP && instr_type == TYPE_HALT)
                    halt_seen = 1'b1;
                expected_ctrl.push_back(decode_ctrl(mode, instr_type, immediate_flag,
                                                    opcode, halt_seen));
            end
            outstanding <= expected_ctrl.size();
        end
    end

endmodule

>>> test/tb_vector_cpu_instruction_decoder.sv
// Testbench top for the instruction decoder: clock, reset, request stimulus and verdict.
// Depends on vcid_pkg, vector_cpu_instruction_decoder and vcid_decode_checker.
`timescale 1ns / 1ps

module tb_vector_cpu_instruction_decoder;
    import vcid_pkg::*;

    // Generous ceiling for ~1700 requests, each at worst a long sender gap plus a
    // long receiver stall plus pipeline latency.
    localparam int CYCLE_LIMIT  = 800000;
    localparam int MAIN_RANDOM  = 1650;
    localparam int AFTER_HALT   = 40;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] mode = '0;
    logic [1:0] instr_type = '0;
    logic       immediate_flag = 1'b0;
    logic [3:0] opcode = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [3:0] scalar_alu_select;
    logic       scalar_reg_write;
    logic       use_immediate;
    logic       vector_reg_write;
    logic       input_select;
    logic       mem_read;
    logic       mem_write;
    logic [3:0] vector_alu_select;
    logic       memory_dump;
    logic [1:0] mode_echo;
    logic [1:0] register_read;
    logic       run_enable;

    int fail_count;
    int outstanding;
    int word_count;
    int dump_count;
    int halted_words;
    int cycles = 0;
    int stall_left = 0;
    int request_idx = 0;

    always #5 clk = ~clk;

    vector_cpu_instruction_decoder dut (.*);

    vcid_decode_checker checker_i (.*);

    // Run ceiling; a hang anywhere ends here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver backpressure. Every fourth window of the cycle counter is left stall-free so
    // the decoder also sees long stretches at full rate; otherwise a stall is raised about
    // a third of the time, and about one stall in fifty is a long one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if ((cycles / 512) % 4 == 1 || $urandom_range(0, 99) < 65)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= 1'b1;
            if ($urandom_range(0, 49) == 0)
                stall_left <= $urandom_range(20, 40);
            else
                stall_left <= $urandom_range(0, 2);
        end
    end

    // Present one request and hold it until the decoder takes it. in_stall is
    // read right after the edge, so it is the value the decoder saw there.
    task automatic issue(input logic [1:0] m, input logic [1:0] t, input logic im,
                         input logic [3:0] op);
        in_valid       <= 1'b1;
        mode           <= m;
        instr_type     <= t;
        immediate_flag <= im;
        opcode         <= op;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        request_idx++;
    endtask

    // Sender gap after a request; zero keeps valid high for back-to-back issue.
    task automatic sender_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if ((request_idx / 150) % 4 == 3 || r < 60)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 3);
        else if (r < 98)
            n = $urandom_range(4, 10);
        else
            n = $urandom_range(20, 40);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every predicted control word has come back.
    // The extra edge lets the checker count a request taken at the last edge.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed instructions with random content; about a fifth get a
    // fully random opcode, and unlisted types show up now and then. Halts are
    // held back until the last stretch since the halted flag never clears.
    task automatic random_request(input bit halt_ok);
        logic [1:0] m;
        logic [1:0] t;
        logic       im;
        logic [3:0] op;
        m  = ($urandom_range(0, 9) == 0) ? MODE_NOP : 2'($urandom_range(1, 3));
        im = 1'($urandom_range(0, 1));
        if (m == MODE_NOP)
            t = (halt_ok && $urandom_range(0, 7) == 0) ? TYPE_HALT : 2'($urandom_range(0, 2));
        else
            t = ($urandom_range(0, 9) == 0) ? TYPE_HALT : 2'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 20)
            op = 4'($urandom_range(0, 15));
        else if (m == MODE_NOP)
            op = $urandom_range(0, 1) ? OPC_DUMP : 4'($urandom_range(0, 14));
        else if (t == TYPE_ARITH)
            op = $urandom_range(0, 1) ? OPC_SUB : 4'd0;
        else if (t == TYPE_LOGIC)
            op = 4'($urandom_range(0, 6));
        else if (t == TYPE_MOVE)
            op = 4'($urandom_range(0, 2));
        else
            op = 4'($urandom_range(0, 15));
        issue(m, t, im, op);
        sender_gap();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: nop, memory dump from two types, add/sub and the unlisted
        // arithmetic opcode
        issue(MODE_NOP, TYPE_ARITH, 1'b0, 4'd0);
        issue(MODE_NOP, TYPE_MOVE, 1'b1, OPC_DUMP);
        issue(MODE_NOP, TYPE_LOGIC, 1'b0, OPC_DUMP);
        issue(MODE_SS, TYPE_ARITH, 1'b0, 4'd0);
        issue(MODE_SS, TYPE_ARITH, 1'b1, OPC_SUB);
        issue(MODE_SS, TYPE_ARITH, 1'b1, 4'd15);
        sender_gap();

        // Every logic opcode plus the first unlisted one, spread over the SS, VV and VS modes
        for (int op = 0; op <= 7; op++)
            issue(2'(op % 3 + 1), TYPE_LOGIC, 1'(op % 2), 4'(op));

        // Moves: assign, store, load, unlisted move opcode and unlisted type, plus a VS sub
        issue(MODE_SS, TYPE_MOVE, 1'b0, OPC_ASSIGN);
        issue(MODE_SS, TYPE_MOVE, 1'b1, OPC_STORE);
        issue(MODE_SS, TYPE_MOVE, 1'b0, OPC_LOAD);
        issue(MODE_SS, TYPE_MOVE, 1'b1, 4'd3);
        issue(MODE_SS, TYPE_HALT, 1'b1, 4'd0);
        issue(MODE_VV, TYPE_MOVE, 1'b0, OPC_ASSIGN);
        issue(MODE_VS, TYPE_ARITH, 1'b0, OPC_SUB);
        issue(MODE_VS, TYPE_MOVE, 1'b1, OPC_STORE);
        issue(MODE_VS, TYPE_MOVE, 1'b1, OPC_LOAD);
        issue(MODE_VS, TYPE_MOVE, 1'b0, 4'd15);
        issue(MODE_VS, TYPE_HALT, 1'b1, 4'd15);
        sender_gap();

        repeat (MAIN_RANDOM) random_request(1'b0);

        // Hold off until the pipe is empty, then halt: run_enable must drop on
        // the halting word and stay low while decoding carries on
        drain();
        issue(MODE_NOP, TYPE_HALT, 1'b1, 4'($urandom_range(0, 15)));
        repeat (AFTER_HALT) random_request(1'b1);

        drain();
        repeat (4) @(posedge clk);

        $display("Checked %0d control words over %0d requests, %0d memory dumps.",
                 word_count, request_idx, dump_count);
        $display("Directed opcode sweep, random traffic, one drain pause; %0d words after halt.",
                 halted_words);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
